>>> design/dwfs_pkg.sv
`timescale 1ns / 1ps

package dwfs_pkg;

	localparam int COORD_W  = 16;
	localparam int EXT_W    = COORD_W + 1;
	localparam int COUNT_W  = 34;
	localparam int FSW_W    = 24;
	localparam int IDX_W    = 5;

	localparam logic [FSW_W-1:0] FULL_SCREEN_RESET = 24'd230400;

	// Words per window sequence (close or open) and last word index per command kind.
	localparam logic [IDX_W-1:0] HALF_WORDS      = 5'd12;
	localparam logic [IDX_W-1:0] LAST_IDX_WINDOW = 5'd23;
	localparam logic [IDX_W-1:0] LAST_IDX_BLACK  = 5'd1;
	localparam logic [IDX_W-1:0] LAST_IDX_SINGLE = 5'd0;

	localparam logic [7:0] CMD_RASET  = 8'h2B;
	localparam logic [7:0] CMD_CASET  = 8'h2A;
	localparam logic [7:0] CMD_RAMWR  = 8'h2C;
	localparam logic [7:0] CMD_INVON  = 8'h21;
	localparam logic [7:0] CMD_INVOFF = 8'h20;
	localparam logic [7:0] FILL_BLACK = 8'h00;
	localparam logic [7:0] FILL_WHITE = 8'hFF;

	typedef enum logic [1:0] {
		OP_BLACK_SCREEN = 2'd0,
		OP_OPEN_WINDOW  = 2'd1,
		OP_INVERT_ON    = 2'd2,
		OP_INVERT_OFF   = 2'd3
	} opcode_t;

	// Position of a word inside one 12-word window sequence.
	typedef enum logic [3:0] {
		POS_RASET        = 4'd0,
		POS_ROW_START_HI = 4'd1,
		POS_ROW_START_LO = 4'd2,
		POS_ROW_END_HI   = 4'd3,
		POS_ROW_END_LO   = 4'd4,
		POS_CASET        = 4'd5,
		POS_COL_START_HI = 4'd6,
		POS_COL_START_LO = 4'd7,
		POS_COL_END_HI   = 4'd8,
		POS_COL_END_LO   = 4'd9,
		POS_RAMWR        = 4'd10,
		POS_FILL         = 4'd11
	} win_pos_t;

	typedef enum logic [1:0] {
		WIN_ROW_START = 2'd0,
		WIN_COL_START = 2'd1,
		WIN_ROW_END   = 2'd2,
		WIN_COL_END   = 2'd3
	} win_field_t;

	typedef logic [COORD_W-1:0] coord_t;
	typedef coord_t window_t [4];

	typedef struct packed {
		opcode_t opcode;
		coord_t  row_start;
		coord_t  col_start;
		coord_t  row_end;
		coord_t  col_end;
	} cmd_t;

	typedef struct packed {
		logic               dcx;
		logic [7:0]         data_byte;
		logic [COUNT_W-1:0] repeat_count;
		logic               end_transfer;
		logic               last;
	} word_t;

	// Inclusive extent of a range; zero when the range is reversed.
	function automatic logic [EXT_W-1:0] extent(input coord_t lo, input coord_t hi);
		logic [EXT_W-1:0] diff;
		begin
			diff = {1'b0, hi} - {1'b0, lo} + {{(EXT_W-1){1'b0}}, 1'b1};
			extent = (hi >= lo) ? diff : '0;
		end
	endfunction

	function automatic logic [IDX_W-1:0] last_index(input opcode_t op);
		logic [IDX_W-1:0] li;
		begin
			unique case (op)
				OP_BLACK_SCREEN: li = LAST_IDX_BLACK;
				OP_OPEN_WINDOW:  li = LAST_IDX_WINDOW;
				default:         li = LAST_IDX_SINGLE;
			endcase
			last_index = li;
		end
	endfunction

endpackage

>>> design/display_window_fill_sequencer_core.sv
`timescale 1ns / 1ps

// Display window fill sequencer.
// The cmd channel (valid/ready, payload cmd) takes one display command per item:
// black screen, open window, invert on or invert off. The word channel
// (valid/ready, payload word) gives the 9-bit link words for it, one item per
// word, each with a D/CX flag, a byte, a repeat count and an end-of-transfer
// mark; the final word of a command carries last.
// The cfg channel writes the black screen fill count; it is always ready and
// should only be used while no command is in flight.
// Flow: an accepted command is registered in the command stage, and its first
// word then moves into the word register. After that one word is produced per
// cycle unless the receiver stalls; an open window command gives 24 words,
// black screen 2 and the invert commands 1.
// The next command is accepted in the cycle its predecessor's final word moves
// into the word register, so commands follow each other without a gap.
// When the receiver stalls, the word register holds its item and the sequencer
// waits; one command may still be taken while the last word waits.
// Reset clears the stored window to zeros and sets the fill count to 230400.
module display_window_fill_sequencer_core
	import dwfs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             word_valid,
	input  logic             word_ready,
	output word_t            word,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [FSW_W-1:0] cfg_data
);

	// Configuration and stored window.
	logic [FSW_W-1:0] full_screen_words_q;
	window_t          current_window_q;

	// Command stage: the command, both windows and their extents.
	logic             busy_s1;
	opcode_t          op_s1;
	logic [IDX_W-1:0] idx_s1;
	window_t          old_win_s1;
	window_t          new_win_s1;
	logic [EXT_W-1:0] rows_s1 [2];
	logic [EXT_W-1:0] cols_s1 [2];

	// Output register.
	logic  word_valid_q;
	word_t word_q;

	logic             advance;
	logic             at_last;
	logic             take_cmd;
	logic             half;
	logic [IDX_W-1:0] pos_raw;
	win_pos_t         pos;
	window_t          win;
	logic [7:0]       fill_byte;
	logic [COUNT_W-1:0] product;
	logic [COUNT_W-1:0] fill_count;
	word_t            next_word;

	assign cfg_ready = 1'b1;

	// A word moves forward when the output register is free or being emptied.
	assign advance   = busy_s1 && (!word_valid_q || word_ready);
	assign at_last   = (idx_s1 == last_index(op_s1));
	assign cmd_ready = !busy_s1 || (advance && at_last);
	assign take_cmd  = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_screen_words_q <= FULL_SCREEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			full_screen_words_q <= cfg_data;
		end
	end

	// The new window becomes the stored one as soon as the command is taken;
	// the old one travels on in the command stage for the closing sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_window_q <= '{default: '0};
		end else if (take_cmd && cmd.opcode == OP_OPEN_WINDOW) begin
			current_window_q[WIN_ROW_START] <= cmd.row_start;
			current_window_q[WIN_COL_START] <= cmd.col_start;
			current_window_q[WIN_ROW_END]   <= cmd.row_end;
			current_window_q[WIN_COL_END]   <= cmd.col_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_s1  <= '0;
		end else if (take_cmd) begin
			busy_s1 <= 1'b1;
			idx_s1  <= '0;
		end else if (advance) begin
			busy_s1 <= !at_last;
			idx_s1  <= idx_s1 + {{(IDX_W-1){1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (take_cmd) begin
			op_s1                     <= cmd.opcode;
			old_win_s1                <= current_window_q;
			new_win_s1[WIN_ROW_START] <= cmd.row_start;
			new_win_s1[WIN_COL_START] <= cmd.col_start;
			new_win_s1[WIN_ROW_END]   <= cmd.row_end;
			new_win_s1[WIN_COL_END]   <= cmd.col_end;
			rows_s1[0] <= extent(current_window_q[WIN_ROW_START],
				current_window_q[WIN_ROW_END]);
			cols_s1[0] <= extent(current_window_q[WIN_COL_START],
				current_window_q[WIN_COL_END]);
			rows_s1[1] <= extent(cmd.row_start, cmd.row_end);
			cols_s1[1] <= extent(cmd.col_start, cmd.col_end);
		end
	end

	// The first twelve words close the old window, the second twelve open
	// the new one; both halves share the word decoder and the multiplier.
	assign half      = (idx_s1 >= HALF_WORDS);
	assign pos_raw   = half ? (idx_s1 - HALF_WORDS) : idx_s1;
	assign pos       = win_pos_t'(pos_raw[3:0]);
	assign win       = half ? new_win_s1 : old_win_s1;
	assign fill_byte = half ? FILL_WHITE : FILL_BLACK;
	assign product   = COUNT_W'(rows_s1[half]) * COUNT_W'(cols_s1[half]);
	assign fill_count = product + {product[COUNT_W-2:0], 1'b0};

	always_comb begin
		next_word              = '0;
		next_word.repeat_count = COUNT_W'(1);
		next_word.last         = at_last;
		unique case (op_s1)
			OP_BLACK_SCREEN: begin
				if (idx_s1 == '0) begin
					next_word.data_byte = CMD_RAMWR;
				end else begin
					next_word.dcx          = 1'b1;
					next_word.data_byte    = FILL_BLACK;
					next_word.repeat_count = COUNT_W'(full_screen_words_q);
					next_word.end_transfer = 1'b1;
				end
			end
			OP_OPEN_WINDOW: begin
				next_word.dcx = 1'b1;
				unique case (pos)
					POS_RASET: begin
						next_word.dcx       = 1'b0;
						next_word.data_byte = CMD_RASET;
					end
					POS_ROW_START_HI: next_word.data_byte = win[WIN_ROW_START][15:8];
					POS_ROW_START_LO: next_word.data_byte = win[WIN_ROW_START][7:0];
					POS_ROW_END_HI:   next_word.data_byte = win[WIN_ROW_END][15:8];
					POS_ROW_END_LO: begin
						next_word.data_byte    = win[WIN_ROW_END][7:0];
						next_word.end_transfer = 1'b1;
					end
					POS_CASET: begin
						next_word.dcx       = 1'b0;
						next_word.data_byte = CMD_CASET;
					end
					POS_COL_START_HI: next_word.data_byte = win[WIN_COL_START][15:8];
					POS_COL_START_LO: next_word.data_byte = win[WIN_COL_START][7:0];
					POS_COL_END_HI:   next_word.data_byte = win[WIN_COL_END][15:8];
					POS_COL_END_LO: begin
						next_word.data_byte    = win[WIN_COL_END][7:0];
						next_word.end_transfer = 1'b1;
					end
					POS_RAMWR: begin
						next_word.dcx       = 1'b0;
						next_word.data_byte = CMD_RAMWR;
					end
					POS_FILL: begin
						next_word.data_byte    = fill_byte;
						next_word.repeat_count = fill_count;
						next_word.end_transfer = 1'b1;
					end
					default: next_word.data_byte = '0;
				endcase
			end
			OP_INVERT_ON: begin
				next_word.data_byte    = CMD_INVON;
				next_word.end_transfer = 1'b1;
			end
			default: begin
				next_word.data_byte    = CMD_INVOFF;
				next_word.end_transfer = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (advance) begin
			word_valid_q <= 1'b1;
		end else if (word_ready) begin
			word_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= next_word;
		end
	end

	assign word_valid = word_valid_q;
	assign word       = word_q;

	// A freshly taken command always starts at its first word.
	a_start_at_first: assert property (@(posedge clk) disable iff (!arst_n)
		take_cmd |=> busy_s1 && idx_s1 == '0)
		else $error("command stage did not restart at the first word");

	// The word index never runs past the final word of its command.
	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> idx_s1 <= last_index(op_s1))
		else $error("word index beyond the end of the command");

	// The final word of every command closes a transfer.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word.last |-> word.end_transfer)
		else $error("final word of a command without end of transfer");

	// Only fill words, which are data words closing a transfer, repeat.
	a_repeat_fill: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word.repeat_count != COUNT_W'(1) |-> word.dcx && word.end_transfer)
		else $error("repeat count other than one on a non-fill word");

endmodule

>>> sim/display_window_fill_sequencer_core_tb.sv
`timescale 1ns / 1ps

module display_window_fill_sequencer_core_tb;
	import dwfs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS   = 90;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_ready;
	cmd_t             cmd = '0;
	logic             word_valid;
	logic             word_ready = 1'b0;
	word_t            word;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [FSW_W-1:0] cfg_data = '0;

	// Commands waiting to be offered, and link words the sequencer still owes us.
	cmd_t  cmd_backlog [$];
	word_t owed_words [$];

	// Shadow of the sequencer's own state.
	window_t          shown_window;
	logic [FSW_W-1:0] black_fill_words = FULL_SCREEN_RESET;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_left = 0;
	bit  cmd_taken = 1'b0;
	int  cycle_count = 0;
	int  mismatches = 0;
	int  words_checked = 0;
	int  opens_seen = 0;
	int  blacks_seen = 0;
	int  inverts_seen = 0;
	int  reversed_seen = 0;
	int  cfg_writes = 0;

	display_window_fill_sequencer_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Every mismatch passes through here; the printout is capped so that a badly
	// broken build cannot flood the log, but every one is counted.
	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic owe_word(input logic dcx, input logic [7:0] data_b,
			input logic [COUNT_W-1:0] rep, input logic endt);
		word_t w;
		w.dcx          = dcx;
		w.data_byte    = data_b;
		w.repeat_count = rep;
		w.end_transfer = endt;
		w.last         = 1'b0;
		owed_words.push_back(w);
	endtask

	// The twelve words that address a window and fill it: row set and column set
	// with 16-bit bounds high byte first, then RAM write and one fill word whose
	// repeat count is rows times columns times three. A reversed extent counts
	// as zero, so the fill word still appears but with a count of zero.
	task automatic owe_window_fill(input window_t w, input logic [7:0] fill_byte);
		logic [EXT_W-1:0]   rows;
		logic [EXT_W-1:0]   cols;
		logic [COUNT_W-1:0] fill_count;
		rows = (w[WIN_ROW_END] >= w[WIN_ROW_START]) ?
			EXT_W'(w[WIN_ROW_END]) - EXT_W'(w[WIN_ROW_START]) + 1'b1 : '0;
		cols = (w[WIN_COL_END] >= w[WIN_COL_START]) ?
			EXT_W'(w[WIN_COL_END]) - EXT_W'(w[WIN_COL_START]) + 1'b1 : '0;
		fill_count = COUNT_W'(rows) * COUNT_W'(cols) * 3;
		owe_word(1'b0, CMD_RASET, 1, 1'b0);
		owe_word(1'b1, w[WIN_ROW_START][15:8], 1, 1'b0);
		owe_word(1'b1, w[WIN_ROW_START][7:0], 1, 1'b0);
		owe_word(1'b1, w[WIN_ROW_END][15:8], 1, 1'b0);
		owe_word(1'b1, w[WIN_ROW_END][7:0], 1, 1'b1);
		owe_word(1'b0, CMD_CASET, 1, 1'b0);
		owe_word(1'b1, w[WIN_COL_START][15:8], 1, 1'b0);
		owe_word(1'b1, w[WIN_COL_START][7:0], 1, 1'b0);
		owe_word(1'b1, w[WIN_COL_END][15:8], 1, 1'b0);
		owe_word(1'b1, w[WIN_COL_END][7:0], 1, 1'b1);
		owe_word(1'b0, CMD_RAMWR, 1, 1'b0);
		owe_word(1'b1, fill_byte, fill_count, 1'b1);
	endtask

	// Works out every link word that an accepted command must produce.
	task automatic predict_link_words(input cmd_t c);
		window_t next_win;
		word_t   tail;
		case (c.opcode)
			OP_BLACK_SCREEN: begin
				blacks_seen++;
				owe_word(1'b0, CMD_RAMWR, 1, 1'b0);
				owe_word(1'b1, FILL_BLACK, COUNT_W'(black_fill_words), 1'b1);
			end
			OP_OPEN_WINDOW: begin
				opens_seen++;
				next_win[WIN_ROW_START] = c.row_start;
				next_win[WIN_COL_START] = c.col_start;
				next_win[WIN_ROW_END]   = c.row_end;
				next_win[WIN_COL_END]   = c.col_end;
				if (c.row_end < c.row_start || c.col_end < c.col_start)
					reversed_seen++;
				// The old window is blanked before the new one is painted white.
				owe_window_fill(shown_window, FILL_BLACK);
				owe_window_fill(next_win, FILL_WHITE);
				shown_window = next_win;
			end
			OP_INVERT_ON: begin
				inverts_seen++;
				owe_word(1'b0, CMD_INVON, 1, 1'b1);
			end
			default: begin
				inverts_seen++;
				owe_word(1'b0, CMD_INVOFF, 1, 1'b1);
			end
		endcase
		tail = owed_words[owed_words.size()-1];
		tail.last = 1'b1;
		owed_words[owed_words.size()-1] = tail;
	endtask

	task automatic check_link_word(input word_t got);
		word_t exp;
		if (owed_words.size() == 0) begin
			report_mismatch($sformatf("word %h arrived with nothing outstanding", got));
		end else begin
			exp = owed_words.pop_front();
			if (got.dcx !== exp.dcx)
				report_mismatch($sformatf("word %0d dcx %b, wanted %b",
					words_checked, got.dcx, exp.dcx));
			if (got.data_byte !== exp.data_byte)
				report_mismatch($sformatf("word %0d byte %h, wanted %h",
					words_checked, got.data_byte, exp.data_byte));
			if (got.repeat_count !== exp.repeat_count)
				report_mismatch($sformatf("word %0d repeat %0d, wanted %0d",
					words_checked, got.repeat_count, exp.repeat_count));
			if (got.end_transfer !== exp.end_transfer)
				report_mismatch($sformatf("word %0d end_transfer %b, wanted %b",
					words_checked, got.end_transfer, exp.end_transfer));
			if (got.last !== exp.last)
				report_mismatch($sformatf("word %0d last %b, wanted %b",
					words_checked, got.last, exp.last));
		end
		words_checked++;
	endtask

	// Both handshakes are observed at the rising edge, before anything the
	// sequencer does at that edge has settled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				predict_link_words(cmd);
				cmd_taken = 1'b1;
			end
			if (word_valid && word_ready)
				check_link_word(word);
		end
	end

	// Command driver: holds an item until it is taken, then either offers the
	// next one from the backlog or idles, as the current phase dictates.
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_taken)) begin
			cmd_taken = 1'b0;
			if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cmd       <= cmd_backlog.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a solid hold-off while hold_left runs down.
	always @(negedge clk) begin
		if (hold_left != 0)
			word_ready <= 1'b0;
		else
			word_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(negedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out with %0d words still owed", owed_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(input opcode_t op, input coord_t rs, input coord_t cs,
			input coord_t re, input coord_t ce);
		cmd_t c;
		c.opcode    = op;
		c.row_start = rs;
		c.col_start = cs;
		c.row_end   = re;
		c.col_end   = ce;
		return c;
	endfunction

	// Mostly open-window commands, since they carry the stored window from one
	// command to the next. Coordinates are a mix of ordered windows, fully
	// random (often reversed) bounds, small windows and windows at the top edge.
	function automatic cmd_t random_cmd();
		cmd_t   c;
		coord_t a;
		coord_t b;
		coord_t p;
		coord_t q;
		if ($urandom_range(0, 9) < 6)
			c.opcode = OP_OPEN_WINDOW;
		else
			c.opcode = opcode_t'($urandom_range(0, 3));
		a = coord_t'($urandom_range(0, 65535));
		b = coord_t'($urandom_range(0, 65535));
		p = coord_t'($urandom_range(0, 65535));
		q = coord_t'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: begin
				c.row_start = a;
				c.row_end   = b;
				c.col_start = p;
				c.col_end   = q;
			end
			1: begin
				c.row_start = (a < b) ? a : b;
				c.row_end   = (a < b) ? b : a;
				c.col_start = (p < q) ? p : q;
				c.col_end   = (p < q) ? q : p;
			end
			2: begin
				c.row_start = coord_t'($urandom_range(0, 15));
				c.row_end   = coord_t'($urandom_range(0, 15));
				c.col_start = coord_t'($urandom_range(0, 15));
				c.col_end   = coord_t'($urandom_range(0, 15));
			end
			default: begin
				c.row_start = 16'hFFFF - coord_t'($urandom_range(0, 7));
				c.row_end   = 16'hFFFF - coord_t'($urandom_range(0, 7));
				c.col_start = 16'hFFFF - coord_t'($urandom_range(0, 7));
				c.col_end   = 16'hFFFF - coord_t'($urandom_range(0, 7));
			end
		endcase
		return c;
	endfunction

	// Waits until every command has been taken and answered, then lets the
	// pipeline settle so that a register write finds the sequencer idle.
	task automatic wait_until_idle();
		while (cmd_backlog.size() != 0 || cmd_valid || owed_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fill_count(input logic [FSW_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		black_fill_words = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(input int items, input int idle_pct, input int stall_pct,
			input logic [FSW_W-1:0] fill_words);
		write_fill_count(fill_words);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (items)
			cmd_backlog.push_back(random_cmd());
		wait_until_idle();
	endtask

	initial begin
		foreach (shown_window[i])
			shown_window[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening with the reset fill count: every command kind, windows
		// at the coordinate extremes, reversed rows, reversed columns and both.
		cmd_backlog.push_back(make_cmd(OP_BLACK_SCREEN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		cmd_backlog.push_back(make_cmd(OP_INVERT_ON, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(OP_INVERT_OFF, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'd100, 16'd0, 16'd99, 16'd10));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'd5, 16'h8000, 16'd5, 16'h7FFF));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
		cmd_backlog.push_back(make_cmd(OP_OPEN_WINDOW, 16'd0, 16'd0, 16'd239, 16'd319));
		cmd_backlog.push_back(make_cmd(OP_BLACK_SCREEN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		wait_until_idle();

		// Black screen at both extremes of the fill count.
		write_fill_count('0);
		cmd_backlog.push_back(make_cmd(OP_BLACK_SCREEN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		cmd_backlog.push_back(make_cmd(OP_INVERT_ON, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		wait_until_idle();
		write_fill_count({FSW_W{1'b1}});
		cmd_backlog.push_back(make_cmd(OP_BLACK_SCREEN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(OP_INVERT_OFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		wait_until_idle();

		// Random phases, one per handshake pattern, each with its own fill count.
		run_random_phase(PHASE_ITEMS, 0, 0, FSW_W'($urandom_range(0, 24'hFFFFFF)));
		run_random_phase(PHASE_ITEMS, 71, 0, 24'd1);
		run_random_phase(PHASE_ITEMS, 0, 71, FSW_W'($urandom_range(0, 24'hFFFFFF)));
		run_random_phase(PHASE_ITEMS, 15, 15, FULL_SCREEN_RESET);

		// Back-pressure: the receiver refuses words for a long stretch while the
		// sender keeps offering, so the sequencer fills and must stall its input.
		write_fill_count(FSW_W'($urandom_range(0, 24'hFFFFFF)));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_left = 400;
		repeat (40)
			cmd_backlog.push_back(random_cmd());
		wait_until_idle();

		$display("Checked %0d link words: %0d open window (%0d reversed), %0d black screen,",
			words_checked, opens_seen, reversed_seen, blacks_seen);
		$display("%0d invert commands, %0d fill count writes, idle, stall and hold-off phases.",
			inverts_seen, cfg_writes);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
design/dwfs_pkg.sv
design/display_window_fill_sequencer_core.sv
sim/display_window_fill_sequencer_core_tb.sv
